// ===== src/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int QUEUE_DEPTH   = 2;
  localparam int MAG_W         = 64;
  localparam int DIGITS        = 20;
  localparam int DIG_IDX_W     = 5;
  localparam int BCD_W         = 4 * DIGITS;
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = MAG_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(STEPS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [1:0] {
    OP_SIGNED = 2'd0,
    OP_FIX4   = 2'd1,
    OP_FIX3   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_VAR,
    KIND_FIX4,
    KIND_FIX3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PICK,
    ST_SIGN,
    ST_DIGIT
  } back_state_e;

  typedef struct packed {
    kind_e            kind;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== src/b2da_front.sv =====
// Front end: accepts commands, classifies the opcode and forms the magnitude.
module b2da_front
  import b2da_pkg::*;
(
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] value_i,
  input  q_status_t   status_i,
  output logic        push_o,
  output item_t       item_o
);

  logic valid_op;

  always_comb begin
    item_o   = '0;
    valid_op = 1'b1;
    case (opcode_e'(opcode_i))
      OP_SIGNED: begin
        item_o.kind = KIND_VAR;
        item_o.neg  = value_i[63];
        item_o.mag  = value_i[63] ? (~value_i + 64'd1) : value_i;
      end
      OP_FIX4: begin
        item_o.kind = KIND_FIX4;
        item_o.mag  = {{(MAG_W-16){1'b0}}, value_i[15:0]};
      end
      OP_FIX3: begin
        item_o.kind = KIND_FIX3;
        item_o.mag  = {{(MAG_W-8){1'b0}}, value_i[7:0]};
      end
      default: begin
        valid_op = 1'b0;
      end
    endcase
  end

  assign busy   = status_i.full;
  assign push_o = start && !status_i.full && valid_op;

endmodule

// ===== src/b2da_fifo.sv =====
// Short queue that decouples the front end from the conversion back end.
module b2da_fifo
  import b2da_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     wr_item_i,
  input  logic      pop_i,
  output item_t     rd_item_o,
  output q_status_t status_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign rd_item_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// ===== src/b2da_back.sv =====
// Back end: four-bit-per-cycle double dabble, then serializes the characters.
module b2da_back
  import b2da_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_status_t   status_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic [7:0]  ascii_char_o,
  output logic        last_o,
  output logic        strobe_o
);

  back_state_e           state_q, state_d;
  kind_e                 kind_q, kind_d;
  logic                  neg_q, neg_d;
  logic [MAG_W-1:0]      mag_q, mag_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIG_IDX_W-1:0]  idx_q, idx_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic                  strobe_q, strobe_d;

  logic [BCD_W-1:0]      conv_bcd;
  logic [MAG_W-1:0]      conv_mag;
  logic [DIG_IDX_W-1:0]  top_idx;
  logic [3:0]            cur_digit;

  always_comb begin
    logic [BCD_W-1:0] b;
    logic [MAG_W-1:0] m;
    b = bcd_q;
    m = mag_q;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], m[MAG_W-1]};
      m = {m[MAG_W-2:0], 1'b0};
    end
    conv_bcd = b;
    conv_mag = m;
  end

  always_comb begin
    top_idx = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_q[d*4 +: 4] != 4'd0) begin
        top_idx = DIG_IDX_W'(d);
      end
    end
  end

  assign cur_digit = bcd_q[{idx_q, 2'b00} +: 4];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!status_i.empty) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (step_q == STEP_W'(STEPS - 1)) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        state_d = (kind_q == KIND_VAR && neg_q) ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (idx_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    kind_d   = kind_q;
    neg_d    = neg_q;
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    step_d   = step_q;
    idx_d    = idx_q;
    char_d   = char_q;
    last_d   = last_q;
    strobe_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop_o  = !status_i.empty;
        kind_d = item_i.kind;
        neg_d  = item_i.neg;
        mag_d  = item_i.mag;
        bcd_d  = '0;
        step_d = '0;
      end
      ST_CONV: begin
        bcd_d  = conv_bcd;
        mag_d  = conv_mag;
        step_d = step_q + STEP_W'(1);
      end
      ST_PICK: begin
        case (kind_q)
          KIND_FIX4: idx_d = DIG_IDX_W'(3);
          KIND_FIX3: idx_d = DIG_IDX_W'(2);
          default:   idx_d = top_idx;
        endcase
      end
      ST_SIGN: begin
        char_d   = CHAR_MINUS;
        last_d   = 1'b0;
        strobe_d = 1'b1;
      end
      ST_DIGIT: begin
        char_d   = CHAR_ZERO + {4'd0, cur_digit};
        last_d   = (idx_q == '0);
        strobe_d = 1'b1;
        idx_d    = idx_q - DIG_IDX_W'(1);
      end
      default: begin
        strobe_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      idx_q    <= idx_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign ascii_char_o = char_q;
  assign last_o       = last_q;
  assign strobe_o     = strobe_q;

endmodule

// ===== src/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// When the back end is idle it pops a taken command from the queue, converts it and then sends its characters.
// The back end handles an item of n characters (1 to 20) in its double dabble unit and then
// sends one character per cycle at the output.
// The front queue takes further commands while the back end works; busy is high when full.
// Reset empties the queue and idles the back end; results cannot be stalled.
module binary_to_decimal_ascii
  import b2da_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] value_i,
  output logic [7:0]  ascii_char_o,
  output logic        last_o,
  output logic        strobe_o
);

  q_status_t status;
  logic      push;
  logic      pop;
  item_t     wr_item;
  item_t     rd_item;

  b2da_front u_front (
    .start    (start),
    .busy     (busy),
    .opcode_i (opcode_i),
    .value_i  (value_i),
    .status_i (status),
    .push_o   (push),
    .item_o   (wr_item)
  );

  b2da_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_item_i (wr_item),
    .pop_i     (pop),
    .rd_item_o (rd_item),
    .status_o  (status)
  );

  b2da_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .status_i     (status),
    .item_i       (rd_item),
    .pop_o        (pop),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_o),
    .strobe_o     (strobe_o)
  );

endmodule

// ===== src/b2da_checker.sv =====
// Port-level checks for the converter, bound to its top level.
module b2da_checker
  import b2da_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic [7:0]  ascii_char_o,
  input logic        last_o,
  input logic        strobe_o
);

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ((ascii_char_o >= CHAR_ZERO && ascii_char_o <= CHAR_ZERO + 8'd9) ||
                  ascii_char_o == CHAR_MINUS))
    else $error("Character outside digits and minus sign.");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && ascii_char_o == CHAR_MINUS) |-> !last_o)
    else $error("Minus sign marked as the final character.");

  a_minus_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && ascii_char_o == CHAR_MINUS) |=> (strobe_o && ascii_char_o != CHAR_MINUS))
    else $error("Minus sign not followed at once by a digit.");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && last_o) |=> !strobe_o)
    else $error("Character beat directly after a final character.");

endmodule

bind binary_to_decimal_ascii b2da_checker u_checker (.*);
